>>> sv/ppghr_pkg.sv
package ppghr_pkg;

	localparam int SmoothTapsDef    = 5;
	localparam int BaselineDepthDef = 100;
	localparam int RateDepthDef     = 10;

	localparam int SampleW = 18;
	localparam int TimeW   = 32;
	localparam int AcW     = 19;
	localparam int BpmW    = 17;
	localparam int AvgW    = 16;
	localparam int CntW    = 4;
	localparam int CfgW    = 18;
	localparam int DivW    = 32;

	localparam logic [DivW-1:0] RateNumerator = 32'd15360000;
	localparam logic [BpmW-1:0] BpmSat        = 17'd76800;
	localparam logic [AvgW-1:0] RingSat       = 16'hFFFF;

	localparam logic [17:0] ThreshRst  = 18'd30;
	localparam logic [15:0] SpacingRst = 16'd200;
	localparam logic [16:0] MinBpmRst  = 17'd10240;
	localparam logic [16:0] MaxBpmRst  = 17'd51200;

	typedef enum logic [1:0] {
		CFG_THRESH,
		CFG_SPACING,
		CFG_MIN_BPM,
		CFG_MAX_BPM
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SSUM,
		ST_SDIV,
		ST_BASE,
		ST_BDIV,
		ST_PEAK,
		ST_RDIV,
		ST_RSUM,
		ST_MDIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> sv/ppghr_if.sv
interface ppghr_in_if import ppghr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SampleW-1:0] ir_sample;
	logic [TimeW-1:0]   time_ms;

	modport source (output valid, ir_sample, time_ms, input ready);
	modport sink (input valid, ir_sample, time_ms, output ready);
endinterface

interface ppghr_out_if import ppghr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  ready_res;
	logic signed [AcW-1:0] ac_signal;
	logic                  beat;
	logic [BpmW-1:0]       bpm_q8;
	logic [AvgW-1:0]       avg_bpm_q8;
	logic [CntW-1:0]       avg_count;

	modport source (output valid, ready_res, ac_signal, beat, bpm_q8, avg_bpm_q8, avg_count,
		input ready);
	modport sink (input valid, ready_res, ac_signal, beat, bpm_q8, avg_bpm_q8, avg_count,
		output ready);
endinterface

>>> sv/ppg_heart_rate_detector_top.sv
// PPG heart-rate detector.
// Input channel smp carries one infrared sample and its millisecond timestamp per
// transfer; output channel res returns exactly one result per sample, in order.
// Registers are written through cfg_we / cfg_idx / cfg_data; the user must write
// them only while the block is idle, which the block itself does not enforce. One
// sequencer steps each sample: a serial sum over the smoothing taps, reciprocal
// multiplies for the smoothing and baseline means, and on a beat that has a nonzero
// previous beat time a 32-step serial divide for the rate plus, when the rate is
// admitted, a sum and a divide over the rate ring. smp.ready is high only while the
// sequencer is idle, so a new sample is taken only after the last result has been
// loaded into the output register.
// The result sits in an output register; the next sample is taken while it waits,
// and a stalled receiver holds the block only once the next result is done.
// Reset clears all history, the rings and the registers to their defaults; the
// baseline ring needs no clearing pass since entries are only read once filled.
// The first BASELINE_DEPTH results carry ready_res = 0 and all other fields zero.
module ppg_heart_rate_detector_top import ppghr_pkg::*; #(
	parameter int SMOOTH_TAPS    = SmoothTapsDef,
	parameter int BASELINE_DEPTH = BaselineDepthDef,
	parameter int RATE_DEPTH     = RateDepthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	ppghr_in_if.sink    smp,
	ppghr_out_if.source res,
	input  logic        cfg_we,
	input  cfg_idx_t    cfg_idx,
	input  logic [CfgW-1:0] cfg_data
);
	localparam int SPW  = (SMOOTH_TAPS > 1) ? $clog2(SMOOTH_TAPS) : 1;
	localparam int RPW  = (RATE_DEPTH > 1) ? $clog2(RATE_DEPTH) : 1;
	localparam int RCW  = $clog2(RATE_DEPTH + 1);
	localparam int BPW  = $clog2(BASELINE_DEPTH);
	localparam int WCW  = $clog2(BASELINE_DEPTH + 1);
	localparam int BSW  = SampleW + $clog2(BASELINE_DEPTH + 1);
	localparam int SSW  = SampleW + $clog2(SMOOTH_TAPS + 1);
	localparam int RSW  = AvgW + $clog2(RATE_DEPTH + 1);
	localparam int ACW  = (SSW > RSW) ? SSW : RSW;
	localparam int LMX  = (SMOOTH_TAPS > RATE_DEPTH) ? SMOOTH_TAPS : RATE_DEPTH;
	localparam int IXW  = $clog2(LMX + 1);

	// floor(x / d) == (x * ceil(2^k / d)) >> k for x < 2^n, k = n + ceil(log2 d)
	localparam int SmK  = SSW + $clog2(SMOOTH_TAPS);
	localparam int SmMW = SSW + 1;
	localparam int SmPW = 2 * SSW + 1;
	localparam logic [SSW:0] SmMul = SmMW'(((64'd1 << SmK) + 64'(SMOOTH_TAPS) - 64'd1)
		/ 64'(SMOOTH_TAPS));
	localparam int BsK  = BSW + $clog2(BASELINE_DEPTH);
	localparam int BsMW = BSW + 1;
	localparam int BsPW = 2 * BSW + 1;
	localparam logic [BSW:0] BsMul = BsMW'(((64'd1 << BsK) + 64'(BASELINE_DEPTH) - 64'd1)
		/ 64'(BASELINE_DEPTH));

	state_t state_q, state_d;

	logic [17:0] thresh_q;
	logic [15:0] spacing_q;
	logic [16:0] min_bpm_q;
	logic [16:0] max_bpm_q;

	logic [TimeW-1:0]   time_q;
	logic [SampleW-1:0] smooth_ring_q [SMOOTH_TAPS];
	logic [SPW-1:0]     spos_q;
	logic [IXW-1:0]     idx_q;
	logic [ACW-1:0]     acc_q;
	logic [SampleW-1:0] smoothed_q;
	logic [SampleW-1:0] base_q;

	logic [SampleW-1:0] bmem [BASELINE_DEPTH];
	logic [SampleW-1:0] brd_q;
	logic [BPW-1:0]     bpos_q;
	logic [BSW-1:0]     bsum_q;
	logic [WCW-1:0]     warm_q;
	logic               warm_item_q;

	logic signed [AcW-1:0] ac_q, prior_q, older_q;
	logic                  latch_q;
	logic [TimeW-1:0]      last_q;
	logic [BpmW-1:0]       latest_q;
	logic                  beat_q;

	logic [AvgW-1:0] rate_ring_q [RATE_DEPTH];
	logic [RPW-1:0]  rpos_q;
	logic            rfull_q;
	logic [AvgW-1:0] mean_q;

	logic            div_go_q;
	logic [DivW-1:0] div_a_q, div_b_q;
	logic [DivW-1:0] div_quo;
	div_stat_t       div_st;

	logic            out_valid_q;
	logic            out_rr_q, out_beat_q;
	logic signed [AcW-1:0] out_ac_q;
	logic [BpmW-1:0] out_bpm_q;
	logic [AvgW-1:0] out_avg_q;
	logic [CntW-1:0] out_cnt_q;

	logic                  accept, can_load, ssum_last, rsum_last;
	logic signed [AcW-1:0] ac_new;
	logic [TimeW-1:0]      gap;
	logic                  is_peak, gap_ok, admit, rate_go, div_go_d, warming;
	logic [RCW-1:0]        rcount;
	logic [SampleW-1:0]    bold;
	logic [BSW-1:0]        bsum_new;
	logic [SmPW-1:0]       sm_prod;
	logic [BsPW-1:0]       bs_prod;

	ppghr_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go_q),
		.dividend (div_a_q),
		.divisor  (div_b_q),
		.quotient (div_quo),
		.stat     (div_st)
	);

	assign accept   = smp.valid && smp.ready;
	assign can_load = !out_valid_q || res.ready;
	assign rcount   = rfull_q ? RCW'(RATE_DEPTH) : RCW'(rpos_q);
	assign ssum_last = (idx_q == IXW'(SMOOTH_TAPS - 1));
	assign rsum_last = (idx_q == IXW'(rcount - 1'b1));
	assign warming   = (warm_q < WCW'(BASELINE_DEPTH));

	assign sm_prod = SmPW'(acc_q[SSW-1:0]) * SmPW'(SmMul);
	assign bs_prod = BsPW'(bsum_q) * BsPW'(BsMul);

	assign ac_new  = $signed({1'b0, smoothed_q}) - $signed({1'b0, base_q});
	assign gap     = time_q - last_q;
	assign gap_ok  = gap > {16'b0, spacing_q};
	assign is_peak = (ac_new > prior_q) && (prior_q > older_q)
		&& (ac_new > $signed({1'b0, thresh_q})) && !latch_q;
	assign rate_go = is_peak && gap_ok && (last_q != '0);
	assign admit   = (div_quo >= {15'b0, min_bpm_q}) && (div_quo <= {15'b0, max_bpm_q});
	assign bold    = warming ? '0 : brd_q;
	assign bsum_new = bsum_q - BSW'(bold) + BSW'(smoothed_q);
	assign div_go_d = ((state_q == ST_PEAK) && rate_go) || ((state_q == ST_RSUM) && rsum_last);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (smp.valid) state_d = ST_SSUM;
			ST_SSUM: if (ssum_last) state_d = ST_SDIV;
			ST_SDIV: state_d = ST_BASE;
			ST_BASE: state_d = warming ? ST_FIN : ST_BDIV;
			ST_BDIV: state_d = ST_PEAK;
			ST_PEAK: state_d = rate_go ? ST_RDIV : ST_FIN;
			ST_RDIV: if (div_st.done) state_d = admit ? ST_RSUM : ST_FIN;
			ST_RSUM: if (rsum_last) state_d = ST_MDIV;
			ST_MDIV: if (div_st.done) state_d = ST_FIN;
			ST_FIN:  if (can_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		smp.ready = (state_q == ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q  <= ThreshRst;
			spacing_q <= SpacingRst;
			min_bpm_q <= MinBpmRst;
			max_bpm_q <= MaxBpmRst;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_THRESH:  thresh_q  <= cfg_data[17:0];
				CFG_SPACING: spacing_q <= cfg_data[15:0];
				CFG_MIN_BPM: min_bpm_q <= cfg_data[16:0];
				CFG_MAX_BPM: max_bpm_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// baseline ring memory
	always_ff @(posedge clk) begin
		if (state_q == ST_SSUM) brd_q <= bmem[bpos_q];
		if (state_q == ST_BASE) bmem[bpos_q] <= smoothed_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SMOOTH_TAPS; i++) smooth_ring_q[i] <= '0;
			for (int i = 0; i < RATE_DEPTH; i++) rate_ring_q[i] <= '0;
			spos_q      <= '0;
			bpos_q      <= '0;
			bsum_q      <= '0;
			warm_q      <= '0;
			warm_item_q <= 1'b0;
			prior_q     <= '0;
			older_q     <= '0;
			latch_q     <= 1'b0;
			last_q      <= '0;
			latest_q    <= '0;
			rpos_q      <= '0;
			rfull_q     <= 1'b0;
			mean_q      <= '0;
			beat_q      <= 1'b0;
			div_go_q    <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			div_go_q <= div_go_d;
			if (state_q == ST_FIN && can_load) out_valid_q <= 1'b1;
			else if (res.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						smooth_ring_q[spos_q] <= smp.ir_sample;
						spos_q <= (spos_q == SPW'(SMOOTH_TAPS - 1)) ? '0 : spos_q + 1'b1;
						idx_q  <= '0;
						beat_q <= 1'b0;
					end
				end
				ST_SSUM: begin
					idx_q <= idx_q + 1'b1;
				end
				ST_BASE: begin
					bsum_q <= bsum_new;
					bpos_q <= (bpos_q == BPW'(BASELINE_DEPTH - 1)) ? '0 : bpos_q + 1'b1;
					warm_item_q <= warming;
					if (warming) warm_q <= warm_q + 1'b1;
				end
				ST_PEAK: begin
					if (is_peak) begin
						if (gap_ok) begin
							last_q  <= time_q;
							latch_q <= 1'b1;
							beat_q  <= 1'b1;
						end
					end else if (ac_new < prior_q) begin
						latch_q <= 1'b0;
					end
					older_q <= prior_q;
					prior_q <= ac_new;
				end
				ST_RDIV: begin
					if (div_st.done) begin
						latest_q <= (div_quo > {15'b0, BpmSat}) ? BpmSat : div_quo[BpmW-1:0];
						if (admit) begin
							rate_ring_q[rpos_q] <= (div_quo > {16'b0, RingSat}) ?
								RingSat : div_quo[AvgW-1:0];
							if (rpos_q == RPW'(RATE_DEPTH - 1)) begin
								rpos_q  <= '0;
								rfull_q <= 1'b1;
							end else begin
								rpos_q <= rpos_q + 1'b1;
							end
							idx_q <= '0;
						end
					end
				end
				ST_RSUM: begin
					idx_q <= idx_q + 1'b1;
				end
				ST_MDIV: begin
					if (div_st.done) mean_q <= div_quo[AvgW-1:0];
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					time_q <= smp.time_ms;
					acc_q  <= '0;
				end
			end
			ST_SSUM: acc_q <= acc_q + ACW'(smooth_ring_q[idx_q[SPW-1:0]]);
			ST_SDIV: smoothed_q <= sm_prod[SmK +: SampleW];
			ST_BDIV: base_q <= bs_prod[BsK +: SampleW];
			ST_PEAK: begin
				ac_q    <= ac_new;
				div_a_q <= RateNumerator;
				div_b_q <= gap;
			end
			ST_RDIV: if (div_st.done) acc_q <= '0;
			ST_RSUM: begin
				acc_q <= acc_q + ACW'(rate_ring_q[idx_q[RPW-1:0]]);
				if (rsum_last) begin
					div_a_q <= DivW'(acc_q + ACW'(rate_ring_q[idx_q[RPW-1:0]]));
					div_b_q <= DivW'(rcount);
				end
			end
			ST_FIN: begin
				if (can_load) begin
					out_rr_q   <= !warm_item_q;
					out_ac_q   <= warm_item_q ? '0 : ac_q;
					out_beat_q <= warm_item_q ? 1'b0 : beat_q;
					out_bpm_q  <= warm_item_q ? '0 : latest_q;
					out_avg_q  <= warm_item_q ? '0 : mean_q;
					out_cnt_q  <= warm_item_q ? '0 : CntW'(rcount);
				end
			end
			default: ;
		endcase
	end

	assign res.valid      = out_valid_q;
	assign res.ready_res  = out_rr_q;
	assign res.ac_signal  = out_ac_q;
	assign res.beat       = out_beat_q;
	assign res.bpm_q8     = out_bpm_q;
	assign res.avg_bpm_q8 = out_avg_q;
	assign res.avg_count  = out_cnt_q;

`ifndef SYNTHESIS
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_go_q |-> !div_st.busy)
		else $error("divider started while busy");
	a_beat_needs_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.beat) |-> res.ready_res)
		else $error("beat reported during warm-up");
	a_take_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_SSUM))
		else $error("sample taken outside idle");
	a_fin_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && can_load) |=> out_valid_q)
		else $error("finished result not loaded");
`endif
endmodule

>>> sv/ppghr_divider.sv
module ppghr_divider import ppghr_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [DivW-1:0] dividend,
	input  logic [DivW-1:0] divisor,
	output logic [DivW-1:0] quotient,
	output div_stat_t       stat
);
	localparam int StepW = $clog2(DivW);

	logic [DivW:0]     rem_q;
	logic [DivW-1:0]   quo_q;
	logic [DivW-1:0]   dvs_q;
	logic [StepW-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DivW:0]     trial;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q[DivW-1:0], quo_q[DivW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == StepW'(DivW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= trial - {1'b0, dvs_q};
				quo_q <= {quo_q[DivW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[DivW-2:0], 1'b0};
			end
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

>>> bench/ppghr_bench_if.sv
`timescale 1ns / 100ps

interface ppghr_cfg_if import ppghr_pkg::*; ();
	logic            we;
	cfg_idx_t        idx;
	logic [CfgW-1:0] data;
endinterface

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import ppghr_pkg::*;

	localparam int Taps = SmoothTapsDef;
	localparam int BaseDepth = BaselineDepthDef;
	localparam int RateDepth = RateDepthDef;
	localparam int StallLimit = 20000;

	typedef struct packed {
		logic                  ready_res;
		logic signed [AcW-1:0] ac_signal;
		logic                  beat;
		logic [BpmW-1:0]       bpm_q8;
		logic [AvgW-1:0]       avg_bpm_q8;
		logic [CntW-1:0]       avg_count;
	} hr_result_t;

	logic clk;
	logic arst_n;
	ppghr_in_if  smp ();
	ppghr_out_if res ();
	ppghr_cfg_if cfg ();

	ppg_heart_rate_detector_top dut (
		.clk(clk), .arst_n(arst_n), .smp(smp.sink), .res(res.source),
		.cfg_we(cfg.we), .cfg_idx(cfg.idx), .cfg_data(cfg.data)
	);

	// predictor state
	logic [17:0] thresh;
	logic [15:0] spacing;
	logic [16:0] min_bpm, max_bpm;
	logic [17:0] smooth_taps [Taps];
	int          smooth_at;
	logic [17:0] base_hist [BaseDepth];
	int          base_at;
	logic [24:0] base_total;
	int          filled;
	int          ac_prev, ac_prev2;
	bit          latched;
	logic [31:0] last_peak;
	logic [16:0] cur_bpm;
	logic [15:0] rate_hist [RateDepth];
	int          rate_at;
	bit          rates_full;
	logic [15:0] rate_mean;

	hr_result_t expected_q[$];
	int  mismatches = 0;
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	bit  hold_recv = 0;
	int  quiet_cycles = 0;
	logic [31:0] now_ms;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	task automatic predictor_reset();
		thresh = ThreshRst; spacing = SpacingRst; min_bpm = MinBpmRst; max_bpm = MaxBpmRst;
		foreach (smooth_taps[i]) smooth_taps[i] = '0;
		foreach (base_hist[i]) base_hist[i] = '0;
		foreach (rate_hist[i]) rate_hist[i] = '0;
		smooth_at = 0; base_at = 0; base_total = '0; filled = 0;
		ac_prev = 0; ac_prev2 = 0; latched = 0; last_peak = '0;
		cur_bpm = '0; rate_at = 0; rates_full = 0; rate_mean = '0;
	endtask

	function automatic hr_result_t predict_heart_rate(logic [17:0] sample, logic [31:0] t);
		hr_result_t r;
		longint sum;
		logic [17:0] smoothed;
		int ac;
		int n;
		logic [31:0] gap, rate;
		r = '0;
		smooth_taps[smooth_at] = sample;
		smooth_at = (smooth_at + 1) % Taps;
		sum = 0;
		foreach (smooth_taps[i]) sum += smooth_taps[i];
		smoothed = 18'(sum / Taps);
		base_total = base_total - base_hist[base_at] + smoothed;
		base_hist[base_at] = smoothed;
		base_at = (base_at + 1) % BaseDepth;
		if (filled < BaseDepth) begin
			filled++;
			return r;
		end
		ac = int'(smoothed) - int'(base_total / BaseDepth);
		if (ac > ac_prev && ac_prev > ac_prev2 && ac > int'(thresh) && !latched) begin
			gap = t - last_peak;
			if (gap > spacing) begin
				if (last_peak != 0) begin
					rate = RateNumerator / gap;
					cur_bpm = (rate > BpmSat) ? BpmSat : 17'(rate);
					if (rate >= min_bpm && rate <= max_bpm) begin
						rate_hist[rate_at] = (rate > RingSat) ? RingSat : 16'(rate);
						rate_at++;
						if (rate_at >= RateDepth) begin
							rate_at = 0;
							rates_full = 1;
						end
						n = rates_full ? RateDepth : rate_at;
						sum = 0;
						for (int i = 0; i < n; i++) sum += rate_hist[i];
						rate_mean = 16'(sum / n);
					end
				end
				last_peak = t;
				latched = 1;
				r.beat = 1;
			end
		end else if (ac < ac_prev) begin
			latched = 0;
		end
		ac_prev2 = ac_prev;
		ac_prev = ac;
		r.ready_res = 1;
		r.ac_signal = AcW'(ac);
		r.bpm_q8 = cur_bpm;
		r.avg_bpm_q8 = rate_mean;
		r.avg_count = CntW'(rates_full ? RateDepth : rate_at);
		return r;
	endfunction

	task automatic send_sample(logic [17:0] sample, logic [31:0] t);
		@(negedge clk);
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) @(negedge clk);
		smp.valid <= 1;
		smp.ir_sample <= sample;
		smp.time_ms <= t;
		do @(posedge clk); while (!smp.ready);
		expected_q.push_back(predict_heart_rate(sample, t));
		@(negedge clk);
		smp.valid <= 0;
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CfgW-1:0] value);
		cfg.we <= 1; cfg.idx <= idx; cfg.data <= value;
		@(negedge clk);
		cfg.we <= 0;
		case (idx)
			CFG_THRESH:  thresh = value[17:0];
			CFG_SPACING: spacing = value[15:0];
			CFG_MIN_BPM: min_bpm = value[16:0];
			default:     max_bpm = value[16:0];
		endcase
		@(negedge clk);
	endtask

	task automatic drain();
		while (expected_q.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	// pulse train: one beat every period ms, 10 ms per sample
	task automatic send_pulses(int count, int period, int amp, int base_lvl);
		int ph;
		for (int i = 0; i < count; i++) begin
			now_ms += 10;
			ph = (now_ms % period) * 100 / period;
			send_sample(18'(base_lvl + ((ph < 30) ? amp * ph / 30 : amp * (100 - ph) / 70)
				+ $urandom_range(3, 0)), now_ms);
		end
	endtask

	always @(posedge clk) begin
		hr_result_t got, want;
		if ((smp.valid && smp.ready) || (res.valid && res.ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > StallLimit) begin
			$display("Mismatches found");
			$finish;
		end
		if (res.valid && res.ready) begin
			got = {res.ready_res, res.ac_signal, res.beat, res.bpm_q8, res.avg_bpm_q8,
				res.avg_count};
			if (expected_q.size() == 0) begin
				$error("result with nothing expected");
				mismatches++;
			end else begin
				want = expected_q.pop_front();
				if (got.ready_res != want.ready_res) begin
					$error("ready_res exp %0d got %0d", want.ready_res, got.ready_res);
					mismatches++;
				end
				if (want.ready_res) begin
					if (got.ac_signal != want.ac_signal) begin
						$error("ac_signal exp %0d got %0d", want.ac_signal, got.ac_signal);
						mismatches++;
					end
					if (got.beat != want.beat) begin
						$error("beat exp %0d got %0d", want.beat, got.beat);
						mismatches++;
					end
					if (got.bpm_q8 != want.bpm_q8) begin
						$error("bpm_q8 exp %0d got %0d", want.bpm_q8, got.bpm_q8);
						mismatches++;
					end
					if (got.avg_bpm_q8 != want.avg_bpm_q8) begin
						$error("avg_bpm_q8 exp %0d got %0d", want.avg_bpm_q8, got.avg_bpm_q8);
						mismatches++;
					end
					if (got.avg_count != want.avg_count) begin
						$error("avg_count exp %0d got %0d", want.avg_count, got.avg_count);
						mismatches++;
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		res.ready <= !hold_recv && !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
	end

	task automatic test_warmup_extremes();
		for (int i = 0; i < 12; i++) begin
			now_ms += 10;
			send_sample((i % 2) ? 18'h3FFFF : 18'h0, now_ms);
		end
		for (int i = 12; i < BaseDepth; i++) begin
			now_ms += 10;
			send_sample(18'($urandom_range(1000, 0) + 100000), now_ms);
		end
		// extremes after warm-up: full-scale step up and down
		for (int i = 0; i < 6; i++) begin
			now_ms += 10;
			send_sample(18'h3FFFF, now_ms);
		end
		for (int i = 0; i < 6; i++) begin
			now_ms += 10;
			send_sample(18'h0, now_ms);
		end
		drain();
	endtask

	task automatic test_wrap_and_zero_time();
		now_ms = 32'hFFFF_FF00;
		send_pulses(150, 700, 4000, 50000);
		now_ms = 32'hFFFF_FFFF - 2000;
		send_pulses(300, 800, 4000, 50000);
		drain();
	endtask

	task automatic test_register_extremes();
		write_reg(CFG_THRESH, 18'h3FFFF);
		write_reg(CFG_SPACING, 18'hFFFF);
		write_reg(CFG_MIN_BPM, 18'd76800);
		write_reg(CFG_MAX_BPM, 18'd0);
		send_pulses(100, 600, 6000, 80000);
		drain();
		write_reg(CFG_THRESH, 18'd0);
		write_reg(CFG_SPACING, 18'd0);
		write_reg(CFG_MIN_BPM, 18'd0);
		write_reg(CFG_MAX_BPM, 18'd76800);
		send_pulses(80, 60, 3000, 30000);
		send_pulses(100, 500, 3000, 30000);
		drain();
	endtask

	task automatic test_random_pulses();
		int phase;
		for (phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 26 : 58) : 0;
			recv_stall_pct = (phase == 2) ? 58 : ((phase == 3) ? 26 : 0);
			write_reg(CFG_THRESH, 18'($urandom_range(200, 0)));
			write_reg(CFG_SPACING, 18'($urandom_range(400, 100)));
			write_reg(CFG_MIN_BPM, 18'($urandom_range(12000, 5000)));
			write_reg(CFG_MAX_BPM, 18'($urandom_range(60000, 30000)));
			send_pulses(133, $urandom_range(1200, 350), $urandom_range(8000, 500),
				$urandom_range(200000, 1000));
			// noise
			for (int i = 0; i < 30; i++) begin
				now_ms += $urandom_range(50, 1);
				send_sample(18'($urandom), $urandom_range(7, 0) == 0 ? $urandom : now_ms);
			end
			drain();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_recv = 1;
				repeat (3000) @(negedge clk);
				hold_recv = 0;
			end
			send_pulses(60, 650, 3000, 40000);
		join
		drain();
	endtask

	initial begin
		arst_n = 0;
		smp.valid = 0; smp.ir_sample = '0; smp.time_ms = '0;
		res.ready = 0;
		cfg.we = 0; cfg.idx = CFG_THRESH; cfg.data = '0;
		now_ms = 32'd1000;
		predictor_reset();
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_warmup_extremes();
		test_wrap_and_zero_time();
		test_register_extremes();
		test_random_pulses();
		test_backpressure();
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

>>> filelist.f
sv/ppghr_pkg.sv
sv/ppghr_if.sv
sv/ppghr_divider.sv
sv/ppg_heart_rate_detector_top.sv
bench/ppghr_bench_if.sv
bench/testbench.sv
